// ===== src/glc_pkg.sv =====
`default_nettype none
package glc_pkg;

  // fixed field widths
  localparam int GLYPH_W = 16;
  localparam int SIZE_W  = 10;
  localparam int STYLE_W = 8;
  localparam int ANGLE_W = 32;
  localparam int SLOT_W  = 9;
  localparam int STAMP_W = 32;

  // action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // full lookup key, compared as one bit pattern
  typedef struct packed {
    logic [GLYPH_W-1:0]        glyph_index;
    logic [SIZE_W-1:0]         pixel_size;
    logic [STYLE_W-1:0]        style_bits;
    logic signed [ANGLE_W-1:0] angle;
  } key_t;

  // one tag memory word
  typedef struct packed {
    key_t               key;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // scanner status toward the controller
  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

endpackage
`default_nettype wire

// ===== src/glc_req_if.sv =====
`default_nettype none
interface glc_req_if;
  import glc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [GLYPH_W-1:0]        glyph_index;
  logic [SIZE_W-1:0]         pixel_size;
  logic [STYLE_W-1:0]        style_bits;
  logic signed [ANGLE_W-1:0] angle;

  modport source (
    output valid, action, glyph_index, pixel_size, style_bits, angle,
    input  ready
  );
  modport sink (
    input  valid, action, glyph_index, pixel_size, style_bits, angle,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/glc_rsp_if.sv =====
`default_nettype none
interface glc_rsp_if;
  import glc_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;

  modport source (
    output valid, hit, slot, evicted,
    input  ready
  );
  modport sink (
    input  valid, hit, slot, evicted,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/glc_ram.sv =====
`default_nettype none
module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/glc_scan.sv =====
`default_nettype none
module glc_scan #(
  parameter int ENTRIES = 512
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     fill,
  input  wire glc_pkg::key_t                    key,
  input  wire glc_pkg::entry_t                  rdata,
  output logic      [$clog2(ENTRIES)-1:0]       raddr,
  output glc_pkg::scan_stat_t                   stat,
  output logic      [$clog2(ENTRIES)-1:0]       match_idx,
  output logic      [$clog2(ENTRIES)-1:0]       min_idx
);
  import glc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic               busy;
  logic [CNT_W-1:0]   issue_addr;
  logic               issuing;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic               done;
  logic               hit;
  logic [STAMP_W-1:0] min_stamp;

  // only the filled prefix of the memory holds valid entries
  assign issuing = busy && (issue_addr < fill);
  assign raddr   = issue_addr[IDX_W-1:0];

  // address sweep and compare of returning words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        issue_addr <= '0;
        pend       <= 1'b0;
        hit        <= 1'b0;
      end else if (busy) begin
        pend     <= issuing;
        pend_idx <= issue_addr[IDX_W-1:0];
        if (issuing) begin
          issue_addr <= issue_addr + CNT_W'(1);
        end
        if (!issuing && !pend) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        if (pend) begin
          // first matching slot wins
          if (!hit && (rdata.key == key)) begin
            hit       <= 1'b1;
            match_idx <= pend_idx;
          end
          // oldest stamp, lowest slot on a tie
          if ((pend_idx == '0) || (rdata.stamp < min_stamp)) begin
            min_stamp <= rdata.stamp;
            min_idx   <= pend_idx;
          end
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.hit  = hit;

endmodule
`default_nettype wire

// ===== src/glyph_cache_lru_tags_unit.sv =====
// operation: a lookup sweeps the valid slots (the first fill slots) once through the tag memory
//   read port, one entry per cycle, then writes back and registers the result; a clear resets
//   the fill count and use counter and registers an empty result; a new request is taken only
//   in the idle state, after the previous one has finished and its result has been registered
// reset: synchronous; clears control state, fill count and use counter;
//   the tag memory is not swept, a zero fill count marks every slot invalid
`default_nettype none
module glyph_cache_lru_tags_unit #(
  parameter int ENTRIES = 512
) (
  input wire logic clk,
  input wire logic rst,
  glc_req_if.sink  req,
  glc_rsp_if.source rsp
);
  import glc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   fill;
  logic [STAMP_W-1:0] use_counter;
  logic [STAMP_W-1:0] stamp_next;
  key_t               cur_key;
  logic               cur_clear;

  logic               req_fire;
  logic               finish_fire;
  logic               full;
  logic [IDX_W-1:0]   sel_idx;

  logic               scan_start;
  scan_stat_t         scan_stat;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   min_idx;
  entry_t             rdata;
  entry_t             wdata;
  logic               we;

  logic               rsp_valid;
  logic               rsp_hit;
  logic [SLOT_W-1:0]  rsp_slot;
  logic               rsp_evicted;

  // handshake
  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign finish_fire = (state == S_FINISH) && (!rsp_valid || rsp.ready);
  assign scan_start  = req_fire && (req.action == ACT_LOOKUP);

  // slot choice: hit slot, else next free slot, else the oldest
  assign full       = (fill == CNT_W'(ENTRIES));
  assign sel_idx    = scan_stat.hit ? match_idx :
                      (full ? min_idx : fill[IDX_W-1:0]);
  assign stamp_next = use_counter + STAMP_W'(1);

  // write back key and fresh stamp
  assign we          = finish_fire && !cur_clear;
  assign wdata.key   = cur_key;
  assign wdata.stamp = stamp_next;

  glc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (we),
    .waddr (sel_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  glc_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .fill      (fill),
    .key       (cur_key),
    .rdata     (rdata),
    .raddr     (raddr),
    .stat      (scan_stat),
    .match_idx (match_idx),
    .min_idx   (min_idx)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_key.glyph_index <= req.glyph_index;
      cur_key.pixel_size  <= req.pixel_size;
      cur_key.style_bits  <= req.style_bits;
      cur_key.angle       <= req.angle;
      cur_clear           <= (req.action == ACT_CLEAR);
    end
  end

  // sequencer, fill count and use counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      use_counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.action == ACT_CLEAR) begin
              fill        <= '0;
              use_counter <= '0;
              state       <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_stat.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish_fire) begin
            if (!cur_clear) begin
              use_counter <= stamp_next;
              if (!scan_stat.hit && !full) begin
                fill <= fill + CNT_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      if (cur_clear) begin
        rsp_hit     <= 1'b0;
        rsp_slot    <= '0;
        rsp_evicted <= 1'b0;
      end else begin
        rsp_hit     <= scan_stat.hit;
        rsp_slot    <= SLOT_W'(sel_idx);
        rsp_evicted <= !scan_stat.hit && full;
      end
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.hit     = rsp_hit;
  assign rsp.slot    = rsp_slot;
  assign rsp.evicted = rsp_evicted;

endmodule
`default_nettype wire

// ===== src/glc_chk.sv =====
`default_nettype none
module glc_chk (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_valid,
  input wire logic                     req_ready,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_ready,
  input wire logic                     rsp_hit,
  input wire logic [glc_pkg::SLOT_W-1:0] rsp_slot,
  input wire logic                     rsp_evicted
);
  import glc_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_hit, rsp_slot, rsp_evicted}))
    else $error("result changed while stalled");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_hit && rsp_evicted))
    else $error("hit flagged with eviction");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind glyph_cache_lru_tags_unit glc_chk u_glc_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_hit     (rsp.hit),
  .rsp_slot    (rsp.slot),
  .rsp_evicted (rsp.evicted)
);
`default_nettype wire
